>>> src/caf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg
// Types, constants and the arctangent table of the attitude filter.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 18;
  localparam int ZSCALE_BITS     = 24;
  localparam int CW              = 62;  // cordic vector width
  localparam int ZW              = 36;  // cordic angle accumulator width
  localparam int AW              = 27;  // accelerometer angle width
  localparam int IW              = 30;  // gyro increment width

  localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] CFG_GYRO_SENS     = 2'd1;
  localparam logic [1:0] CFG_BLEND_GAIN    = 2'd2;

  localparam logic signed [35:0] HALF_TURN    = 36'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic signed [35:0] FULL_TURN    = 36'sd360 <<< ANGLE_FRAC_BITS;
  localparam logic signed [35:0] QUARTER_TURN = 36'sd90 <<< ANGLE_FRAC_BITS;
  localparam logic signed [35:0] YAW_MAX      = 36'sd2147483647;
  localparam logic signed [35:0] YAW_MIN      = -36'sd2147483648;
  localparam logic signed [ZW-1:0] Z_HALF     = 36'sd180 <<< ZSCALE_BITS;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } caf_item_t;

  typedef struct packed {
    logic      valid;
    caf_item_t item;
  } caf_queue_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] x;
    logic signed [33:0] y;
  } caf_cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [AW-1:0] angle;
  } caf_cordic_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_CR,
    S_CP,
    S_MUL,
    S_DIV,
    S_BLEND,
    S_DONE
  } caf_state_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ZW-1:0] caf_atan(input logic [4:0] idx);
    case (idx)
      5'd0:    caf_atan = 36'sd754974720;
      5'd1:    caf_atan = 36'sd445687602;
      5'd2:    caf_atan = 36'sd235489088;
      5'd3:    caf_atan = 36'sd119537938;
      5'd4:    caf_atan = 36'sd60000934;
      5'd5:    caf_atan = 36'sd30029717;
      5'd6:    caf_atan = 36'sd15018523;
      5'd7:    caf_atan = 36'sd7509720;
      5'd8:    caf_atan = 36'sd3754917;
      5'd9:    caf_atan = 36'sd1877466;
      5'd10:   caf_atan = 36'sd938734;
      5'd11:   caf_atan = 36'sd469367;
      5'd12:   caf_atan = 36'sd234684;
      5'd13:   caf_atan = 36'sd117342;
      5'd14:   caf_atan = 36'sd58671;
      5'd15:   caf_atan = 36'sd29335;
      5'd16:   caf_atan = 36'sd14668;
      5'd17:   caf_atan = 36'sd7334;
      5'd18:   caf_atan = 36'sd3667;
      5'd19:   caf_atan = 36'sd1833;
      5'd20:   caf_atan = 36'sd917;
      5'd21:   caf_atan = 36'sd458;
      5'd22:   caf_atan = 36'sd229;
      5'd23:   caf_atan = 36'sd115;
      default: caf_atan = 36'sd0;
    endcase
  endfunction

endpackage

>>> src/caf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_in_if
// Sample channel: raw accelerometer and gyroscope counts.
// ----------------------------------------------------------------------------
interface caf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

>>> src/caf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_out_if
// Result channel: roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
interface caf_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] roll_out;
  logic signed [23:0] pitch_out;
  logic signed [31:0] yaw_out;

  modport source (output valid, roll_out, pitch_out, yaw_out, input ready);
  modport sink (input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface

>>> src/complementary_attitude_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_attitude_filter
// Roll, pitch and yaw from raw accelerometer and gyroscope counts.
//
//   channel   direction  transaction
//   in_ch     sink       six raw 16-bit sample counts
//   out_ch    source     roll_out, pitch_out, yaw_out
//   cfg_*     input      write of sample period, sensitivity, blend gain
//
// one transaction runs from queue pop to result register through the
// 32-step square root, two passes of the cordic unit and three 29-step
// gyro divisions on one shared divider
// synchronous active-low reset clears the angles and loads default settings
// a sample queue takes input until full while the sequencer or output stalls
// ----------------------------------------------------------------------------
module complementary_attitude_filter
  import caf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  caf_in_if.sink      in_ch,
  caf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  caf_queue_t q_head;
  logic       q_pop;

  caf_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (q_pop),
    .head  (q_head)
  );

  caf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

>>> src/caf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_front
// Sample queue between the input channel and the compute sequencer.
// ----------------------------------------------------------------------------
module caf_front
  import caf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  caf_in_if.sink     in_ch,
  input  logic       pop,
  output caf_queue_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  caf_item_t         mem [DEPTH];
  logic [PW-1:0]     wr_r, rd_r;
  logic [NW-1:0]     cnt_r;
  logic              push;
  caf_item_t         item_in;

  assign in_ch.ready = (cnt_r != NW'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != '0);
  assign head.item   = mem[rd_r];

  always_comb begin
    item_in.accel_x = in_ch.accel_x;
    item_in.accel_y = in_ch.accel_y;
    item_in.accel_z = in_ch.accel_z;
    item_in.rate_x  = in_ch.rate_x;
    item_in.rate_y  = in_ch.rate_y;
    item_in.rate_z  = in_ch.rate_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> src/caf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_cordic
// Iterative vectoring cordic: atan2(y, x) in degrees, one step per cycle.
// ----------------------------------------------------------------------------
module caf_cordic
  import caf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  caf_cordic_req_t req,
  output caf_cordic_rsp_t rsp
);

  logic                 busy_r, done_r, zero_r;
  logic [4:0]           i_r;
  logic signed [CW-1:0] x_r, y_r, xs, ys, x_in, y_in;
  logic signed [ZW-1:0] z_r, z_rnd;

  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign x_in  = CW'(req.x) <<< ZSCALE_BITS;
  assign y_in  = CW'(req.y) <<< ZSCALE_BITS;
  assign z_rnd = (z_r + (ZW'(1) <<< (ZSCALE_BITS - ANGLE_FRAC_BITS - 1)))
                 >>> (ZSCALE_BITS - ANGLE_FRAC_BITS);

  assign rsp.done  = done_r;
  assign rsp.angle = zero_r ? '0 : AW'(z_rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      zero_r <= (req.x == '0) && (req.y == '0);
      if (req.x < 0) begin
        x_r <= -x_in;
        y_r <= -y_in;
        z_r <= (req.y >= 0) ? Z_HALF : -Z_HALF;
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (!y_r[CW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + caf_atan(i_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - caf_atan(i_r);
      end
    end
  end

endmodule

>>> src/caf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_back
// Sequencer: square root, two cordic angles, gyro integration, blending.
// ----------------------------------------------------------------------------
module caf_back
  import caf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  caf_queue_t  q_head,
  output logic        q_pop,
  caf_out_if.source   out_ch
);

  caf_state_t           state_r, state_nxt;
  logic [5:0]           cnt_r;
  logic [1:0]           ax_r;
  caf_item_t            item_r;
  logic [15:0]          sp_r, sens_r, sens_eff;
  logic [16:0]          gain_r, gain_eff;
  logic [31:0]          sqsh_r, root_r;
  logic [32:0]          rem_r;
  logic [34:0]          sq_tmp, sq_trial;
  logic                 sq_ge;
  logic signed [AW-1:0] tilt_roll_r, tilt_pitch_r, acc_sel;
  logic                 neg_r;
  logic [28:0]          dvd_r;
  logic [15:0]          drem_r;
  logic [16:0]          d_tmp;
  logic                 d_ge;
  logic [31:0]          mag;
  logic [32:0]          num_abs;
  logic [48:0]          big;
  logic signed [IW-1:0] inc;
  logic signed [33:0]   angle_sel, gyro_r, d_r;
  logic signed [35:0]   blend_r, wrapped, roll_fin, pitch_fin, yaw_fin, gyro_x;
  logic signed [15:0]   rate_sel;
  logic signed [33:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [51:0]   prod, blend_sum;
  logic signed [24:0]   roll_r, roll_new_r;
  logic signed [23:0]   pitch_r, pitch_new_r;
  logic signed [31:0]   yaw_r, yaw_new_r;
  logic                 out_valid_r, can_load, start_r;
  logic signed [33:0]   req_x_r, req_y_r;
  caf_cordic_req_t      creq;
  caf_cordic_rsp_t      crsp;

  caf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  assign creq.start = start_r;
  assign creq.x     = req_x_r;
  assign creq.y     = req_y_r;

  assign out_ch.valid = out_valid_r;
  assign can_load     = !out_valid_r || out_ch.ready;

  assign sens_eff = (sens_r == '0) ? 16'd1 : sens_r;
  assign gain_eff = (gain_r > 17'd65536) ? 17'd65536 : gain_r;

  always_comb begin
    case (ax_r)
      2'd0: begin
        rate_sel  = item_r.rate_x;
        angle_sel = 34'(roll_r);
        acc_sel   = tilt_roll_r;
      end
      2'd1: begin
        rate_sel  = item_r.rate_y;
        angle_sel = 34'(pitch_r);
        acc_sel   = tilt_pitch_r;
      end
      default: begin
        rate_sel  = item_r.rate_z;
        angle_sel = 34'(yaw_r);
        acc_sel   = tilt_pitch_r;
      end
    endcase
  end

  // shared multiplier
  always_comb begin
    case (state_r)
      S_SQ: begin
        mul_a = cnt_r[0] ? 34'(item_r.accel_z) : 34'(item_r.accel_y);
        mul_b = cnt_r[0] ? 18'(item_r.accel_z) : 18'(item_r.accel_y);
      end
      S_MUL: begin
        mul_a = 34'(rate_sel);
        mul_b = $signed({2'b00, sp_r});
      end
      S_BLEND: begin
        mul_a = d_r;
        mul_b = $signed({1'b0, gain_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // square root and divider steps
  assign sq_tmp   = {rem_r, sqsh_r[31:30]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_tmp >= sq_trial);
  assign d_tmp    = {drem_r, dvd_r[28]};
  assign d_ge     = (d_tmp >= {1'b0, sens_eff});

  assign num_abs = prod[32] ? 33'(-prod[32:0]) : prod[32:0];
  assign mag     = num_abs[31:0];
  assign big     = {1'b0, mag, 16'b0} + {14'b0, sens_eff, 19'b0};
  assign inc     = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

  assign blend_sum = (52'(acc_sel) <<< 16) + prod + 52'sd32768;

  // wrap, clamp and saturate
  always_comb begin
    if (blend_r > HALF_TURN) begin
      wrapped = blend_r - FULL_TURN;
    end else if (blend_r < -HALF_TURN) begin
      wrapped = blend_r + FULL_TURN;
    end else begin
      wrapped = blend_r;
    end
    if (wrapped > HALF_TURN) begin
      roll_fin = HALF_TURN;
    end else if (wrapped < -HALF_TURN) begin
      roll_fin = -HALF_TURN;
    end else begin
      roll_fin = wrapped;
    end
    if (blend_r > QUARTER_TURN) begin
      pitch_fin = QUARTER_TURN;
    end else if (blend_r < -QUARTER_TURN) begin
      pitch_fin = -QUARTER_TURN;
    end else begin
      pitch_fin = blend_r;
    end
    gyro_x = 36'(gyro_r);
    if (gyro_x > YAW_MAX) begin
      yaw_fin = YAW_MAX;
    end else if (gyro_x < YAW_MIN) begin
      yaw_fin = YAW_MIN;
    end else begin
      yaw_fin = gyro_x;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (cnt_r == 6'd1) begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == 6'd31) begin
          state_nxt = S_CR;
        end
      end
      S_CR: begin
        if (crsp.done) begin
          state_nxt = S_CP;
        end
      end
      S_CP: begin
        if (crsp.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == 6'd28) begin
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        if (cnt_r == 6'd2) begin
          state_nxt = (ax_r == 2'd2) ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ax_r        <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      sp_r        <= 16'd5243;
      sens_r      <= 16'd131;
      gain_r      <= 17'd64225;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
      start_r <= ((state_r == S_SQRT) && (state_nxt == S_CR)) ||
                 ((state_r == S_CR) && (state_nxt == S_CP));
      if (state_r == S_IDLE) begin
        ax_r <= '0;
      end else if ((state_r == S_BLEND) && (state_nxt != S_BLEND)) begin
        ax_r <= ax_r + 1'b1;
      end
      if ((state_r == S_DONE) && can_load) begin
        out_valid_r <= 1'b1;
        roll_r      <= roll_new_r;
        pitch_r     <= pitch_new_r;
        yaw_r       <= yaw_new_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: sp_r   <= cfg_data[15:0];
          CFG_GYRO_SENS:     sens_r <= cfg_data[15:0];
          CFG_BLEND_GAIN:    gain_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r <= q_head.item;
      end
      S_SQ: begin
        if (cnt_r[0]) begin
          sqsh_r <= sqsh_r + 32'(prod);
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          sqsh_r <= 32'(prod);
        end
      end
      S_SQRT: begin
        rem_r   <= sq_ge ? 33'(sq_tmp - sq_trial) : sq_tmp[32:0];
        root_r  <= {root_r[30:0], sq_ge};
        sqsh_r  <= {sqsh_r[29:0], 2'b00};
        req_x_r <= 34'(item_r.accel_z) <<< 16;
        req_y_r <= 34'(item_r.accel_y) <<< 16;
      end
      S_CR: begin
        tilt_roll_r <= crsp.angle;
        req_x_r     <= $signed({2'b00, root_r});
        req_y_r     <= -(34'(item_r.accel_x) <<< 16);
      end
      S_CP: begin
        tilt_pitch_r <= crsp.angle;
      end
      S_MUL: begin
        neg_r  <= prod[32];
        dvd_r  <= big[48:20];
        drem_r <= '0;
      end
      S_DIV: begin
        drem_r <= d_ge ? 16'(d_tmp - {1'b0, sens_eff}) : d_tmp[15:0];
        dvd_r  <= {dvd_r[27:0], d_ge};
      end
      S_BLEND: begin
        case (cnt_r[1:0])
          2'd0: begin
            gyro_r <= angle_sel + 34'(inc);
            d_r    <= angle_sel + 34'(inc) - 34'(acc_sel);
          end
          2'd1: begin
            blend_r <= 36'(blend_sum >>> 16);
          end
          default: begin
            case (ax_r)
              2'd0:    roll_new_r  <= 25'(roll_fin);
              2'd1:    pitch_new_r <= 24'(pitch_fin);
              default: yaw_new_r   <= 32'(yaw_fin);
            endcase
          end
        endcase
      end
      S_DONE: begin
        if (can_load) begin
          out_ch.roll_out  <= roll_new_r;
          out_ch.pitch_out <= pitch_new_r;
          out_ch.yaw_out   <= yaw_new_r;
        end
      end
      default: ;
    endcase
  end

endmodule
